// File: src/ece_pkg.sv
// Package for the easing curve evaluator.
// Holds the curve selector codes and the fixed-point format of the exponential table.
// No dependencies.
`default_nettype none

package ece_pkg;

    // Fractional bits of the table of fractional powers of two, and its word width.
    localparam int ROM_FRAC = 30;
    localparam int ROM_W    = ROM_FRAC + 1;

    typedef enum logic [3:0] {
        CRV_LINEAR     = 4'd0,
        CRV_IN_QUAD    = 4'd1,
        CRV_OUT_QUAD   = 4'd2,
        CRV_INOUT_QUAD = 4'd3,
        CRV_IN_EXPO    = 4'd4,
        CRV_OUT_EXPO   = 4'd5,
        CRV_IN_BACK    = 4'd6,
        CRV_OUT_BACK   = 4'd7,
        CRV_BOUNCE     = 4'd8
    } t_curve;

endpackage

`default_nettype wire

// File: src/easing_curve_eval_core.sv
// Easing curve evaluator: seven-stage pipeline from curve code and progress to eased value.
// Depends on ece_pkg for curve codes and the exponential table format.
`default_nettype none

// Usage:
// An input transaction carries i_curve (curve code) and i_progress (t in unsigned
// Q1.FRAC_BITS). It is taken at a clock edge where i_valid and o_ready are both high.
// Each input produces exactly one output transaction with o_eased in signed
// Q2.FRAC_BITS, taken where o_valid and i_ready are both high. Results leave in order.
// Each result passes through the register stages in order before it is on o_eased.
// The pipeline holds seven results in its seven register stages (input capture,
// square, round, cube and scale, round, scale, output). Throughput: one transaction
// per cycle while the receiver does not stall; no stage holds more than two multipliers.
// Stalls: each stage advances when it is empty or the stage after it advances, so
// while the receiver holds i_ready low the pipeline keeps filling its empty stages
// and o_ready falls only once all seven stages are occupied.
// The exponential table is a constant computed at elaboration; nothing needs to be
// loaded. Reset empties the pipeline and drops o_valid on the next edge.
module easing_curve_eval_core #(
    parameter int FRAC_BITS       = 16,
    parameter int EXP_TABLE_DEPTH = 64
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_valid,
    output logic                        o_ready,
    input  wire  [3:0]                  i_curve,
    input  wire  [FRAC_BITS:0]          i_progress,
    output logic                        o_valid,
    input  wire                         i_ready,
    output logic signed [FRAC_BITS+1:0] o_eased
);
    import ece_pkg::*;

    localparam int FB = FRAC_BITS;
    localparam int OW = FB + 2;
    localparam int DW = $clog2(EXP_TABLE_DEPTH + 1);
    localparam int NSTG = 7;

    localparam logic [FB:0] ONE_P = (FB + 1)'(1) << FB;
    localparam longint unsigned C1_L =
        (64'd170158 * (64'd1 << FB) + 64'd50000) / 64'd100000;
    localparam logic [FB:0]   C1_Q = (FB + 1)'(C1_L);
    localparam logic [FB+1:0] C3_Q = (FB + 2)'(C1_L + (64'd1 << FB));

    localparam logic [DW-1:0] DEPTH_C = DW'(EXP_TABLE_DEPTH);
    localparam logic [4:0]    EXP_SH0 = 5'(ROM_FRAC - FB);

    localparam logic [FB+3:0] BNC_T1 = (FB + 4)'(4) << FB;
    localparam logic [FB+3:0] BNC_T2 = (FB + 4)'(8) << FB;
    localparam logic [FB+3:0] BNC_T3 = (FB + 4)'(10) << FB;
    localparam logic [FB+4:0] BNC_C1 = (FB + 5)'(6) << FB;
    localparam logic [FB+4:0] BNC_C2 = (FB + 5)'(9) << FB;
    localparam logic [FB+4:0] BNC_C3 = (FB + 5)'(21) << FB;
    localparam logic [FB:0]   BNC_B1 = (FB + 1)'(3) << (FB - 2);
    localparam logic [FB:0]   BNC_B2 = (FB + 1)'(15) << (FB - 4);
    localparam logic [FB:0]   BNC_B3 = (FB + 1)'(63) << (FB - 6);

    localparam logic signed [FB+3:0] SAT_HI = (FB + 4)'((64'd1 << (FB + 1)) - 64'd1);
    localparam logic signed [FB+3:0] SAT_LO = -SAT_HI - (FB + 4)'(1);

    typedef enum logic [1:0] {SEG_FIRST, SEG_SECOND, SEG_THIRD, SEG_LAST} t_seg;
    typedef logic [ROM_W-1:0] t_rom [0:EXP_TABLE_DEPTH];

    // Table of 2^(-k/DEPTH) in Q30, built from the largest step whose DEPTH-fold
    // product stays at or below one half, each product rounded half up.
    function automatic logic [63:0] rom_mul(input logic [63:0] a, input logic [63:0] b);
        return (a * b + (64'd1 << (ROM_FRAC - 1))) >> ROM_FRAC;
    endfunction

    function automatic logic [63:0] rom_pow(input logic [63:0] r);
        logic [63:0] acc;
        acc = 64'd1 << ROM_FRAC;
        for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
            acc = rom_mul(acc, r);
        end
        return acc;
    endfunction

    function automatic t_rom build_rom();
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        t_rom        tab;
        lo = 64'd1 << (ROM_FRAC - 1);
        hi = 64'd1 << ROM_FRAC;
        while (hi - lo > 64'd1) begin
            mid = lo + ((hi - lo) >> 1);
            if (rom_pow(mid) <= (64'd1 << (ROM_FRAC - 1))) begin
                lo = mid;
            end else begin
                hi = mid;
            end
        end
        tab[0] = ROM_W'(64'd1 << ROM_FRAC);
        for (int k = 1; k <= EXP_TABLE_DEPTH; k++) begin
            tab[k] = ROM_W'(rom_mul(64'(tab[k-1]), lo));
        end
        return tab;
    endfunction

    localparam t_rom EXP_ROM = build_rom();

    // Pipeline control.
    logic [NSTG:1] r_vld;
    logic [NSTG:1] rdy;

    always_comb begin
        rdy[NSTG] = !r_vld[NSTG] || i_ready;
        for (int k = NSTG - 1; k >= 1; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[1]) begin
                r_vld[1] <= i_valid;
            end
            for (int k = 2; k <= NSTG; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_ready = rdy[1];
    assign o_valid = r_vld[NSTG];

    // Stage 1: operand selection, exponent split and bounce segment.
    t_curve          n1_curve;
    logic            n1_zero;
    logic            n1_full;
    logic            n1_hi;
    t_seg            n1_seg;
    logic [FB-1:0]   n1_x;
    logic [FB+1:0]   n1_m;
    logic [3:0]      n1_n;
    logic [DW-1:0]   n1_idx;
    logic [FB-1:0]   n1_rem;

    logic [FB-1:0]   s1_tf;
    logic [FB-1:0]   s1_u;
    logic            s1_use_u;
    logic [FB+3:0]   s1_e;
    logic [FB+DW-1:0] s1_s;
    logic [FB+3:0]   s1_t11;
    logic [FB+4:0]   s1_av;
    logic [FB+4:0]   s1_cv;
    logic [FB+4:0]   s1_w;

    always_comb begin
        n1_curve = t_curve'(i_curve);
        s1_tf    = i_progress[FB-1:0];
        s1_u     = FB'(0) - s1_tf;
        n1_zero  = (i_progress == '0);
        n1_full  = i_progress[FB];
        n1_hi    = s1_tf[FB-1];
        case (n1_curve)
            CRV_OUT_QUAD, CRV_IN_EXPO, CRV_OUT_BACK: s1_use_u = 1'b1;
            CRV_INOUT_QUAD:                          s1_use_u = n1_hi;
            default:                                 s1_use_u = 1'b0;
        endcase
        n1_x = s1_use_u ? s1_u : s1_tf;

        s1_e   = (FB + 4)'({n1_x, 3'b000}) + (FB + 4)'({n1_x, 1'b0});
        n1_n   = s1_e[FB+3:FB];
        s1_s   = (FB + DW)'(s1_e[FB-1:0]) * (FB + DW)'(DEPTH_C);
        n1_idx = s1_s[FB+DW-1:FB];
        n1_rem = s1_s[FB-1:0];

        s1_t11 = (FB + 4)'({s1_tf, 3'b000}) + (FB + 4)'({s1_tf, 1'b0}) + (FB + 4)'(s1_tf);
        if (s1_t11 < BNC_T1) begin
            n1_seg = SEG_FIRST;
        end else if (s1_t11 < BNC_T2) begin
            n1_seg = SEG_SECOND;
        end else if (s1_t11 < BNC_T3) begin
            n1_seg = SEG_THIRD;
        end else begin
            n1_seg = SEG_LAST;
        end
        case (n1_seg)
            SEG_SECOND: s1_cv = BNC_C1;
            SEG_THIRD:  s1_cv = BNC_C2;
            SEG_LAST:   s1_cv = BNC_C3;
            default:    s1_cv = '0;
        endcase
        s1_av = (n1_seg == SEG_LAST) ? {s1_t11, 1'b0} : {1'b0, s1_t11};
        s1_w  = (s1_av >= s1_cv) ? (s1_av - s1_cv) : (s1_cv - s1_av);
        n1_m  = (n1_curve == CRV_BOUNCE) ? s1_w[FB+1:0] : {2'b00, n1_x};
    end

    t_curve          r1_curve;
    logic            r1_zero;
    logic            r1_full;
    logic            r1_hi;
    t_seg            r1_seg;
    logic [FB-1:0]   r1_x;
    logic [FB+1:0]   r1_m;
    logic [3:0]      r1_n;
    logic [DW-1:0]   r1_idx;
    logic [FB-1:0]   r1_rem;

    // Stage 2: square of the selected operand and table read.
    logic [2*FB+3:0]   n2_sq;
    logic [ROM_W-1:0]  n2_a;
    logic [ROM_W-1:0]  s2_b;
    logic [ROM_W-1:0]  s2_diff;
    logic [ROM_FRAC-1:0] n2_d;

    always_comb begin
        n2_sq   = (2 * FB + 4)'(r1_m) * (2 * FB + 4)'(r1_m);
        n2_a    = EXP_ROM[r1_idx];
        s2_b    = EXP_ROM[r1_idx + DW'(1)];
        s2_diff = (n2_a >= s2_b) ? (n2_a - s2_b) : '0;
        n2_d    = s2_diff[ROM_FRAC-1:0];
    end

    t_curve              r2_curve;
    logic                r2_zero;
    logic                r2_full;
    logic                r2_hi;
    t_seg                r2_seg;
    logic [FB-1:0]       r2_x;
    logic [2*FB+3:0]     r2_sq;
    logic [ROM_W-1:0]    r2_a;
    logic [ROM_FRAC-1:0] r2_d;
    logic [3:0]          r2_n;
    logic [FB-1:0]       r2_rem;

    // Stage 3: rounding of the square; quadratic and bounce results are final here.
    logic [FB:0]           n3_t2r;
    logic [FB:0]           n3_res;
    logic [ROM_FRAC+FB-1:0] n3_pd;
    logic [2*FB+4:0]       s3_r0;
    logic [2*FB+4:0]       s3_r1;
    logic [2*FB+4:0]       s3_r4;
    logic [2*FB+4:0]       s3_r6;
    logic [FB:0]           s3_io;
    logic [FB:0]           s3_bnc;

    always_comb begin
        s3_r0  = {1'b0, r2_sq} + ((2 * FB + 5)'(1) << (FB - 1));
        s3_r1  = {1'b0, r2_sq} + ((2 * FB + 5)'(1) << (FB - 2));
        s3_r4  = {1'b0, r2_sq} + ((2 * FB + 5)'(1) << (FB + 3));
        s3_r6  = {1'b0, r2_sq} + ((2 * FB + 5)'(1) << (FB + 5));
        n3_t2r = s3_r0[2*FB:FB];
        s3_io  = s3_r1[2*FB-1:FB-1];
        case (r2_seg)
            SEG_SECOND: s3_bnc = s3_r4[2*FB+4:FB+4] + BNC_B1;
            SEG_THIRD:  s3_bnc = s3_r4[2*FB+4:FB+4] + BNC_B2;
            SEG_LAST:   s3_bnc = (FB + 1)'(s3_r6[2*FB+4:FB+6]) + BNC_B3;
            default:    s3_bnc = s3_r4[2*FB+4:FB+4];
        endcase
        case (r2_curve)
            CRV_IN_QUAD:    n3_res = n3_t2r;
            CRV_OUT_QUAD:   n3_res = ONE_P - n3_t2r;
            CRV_INOUT_QUAD: n3_res = r2_hi ? (ONE_P - s3_io) : s3_io;
            CRV_BOUNCE:     n3_res = s3_bnc;
            default:        n3_res = {1'b0, r2_x};
        endcase
        n3_pd = (ROM_FRAC + FB)'(r2_d) * (ROM_FRAC + FB)'(r2_rem);
    end

    t_curve                 r3_curve;
    logic                   r3_zero;
    logic                   r3_full;
    logic [FB-1:0]          r3_x;
    logic [FB:0]            r3_t2r;
    logic [FB:0]            r3_res;
    logic [ROM_W-1:0]       r3_a;
    logic [3:0]             r3_n;
    logic [ROM_FRAC+FB-1:0] r3_pd;

    // Stage 4: cube and overshoot products, table interpolation.
    logic [2*FB:0]      n4_pc;
    logic [2*FB+1:0]    n4_p1;
    logic [ROM_W-1:0]   n4_v;
    logic [ROM_FRAC+FB:0] s4_pdr;

    always_comb begin
        n4_pc  = (2 * FB + 1)'(r3_t2r) * (2 * FB + 1)'(r3_x);
        n4_p1  = (2 * FB + 2)'(C1_Q) * (2 * FB + 2)'(r3_t2r);
        s4_pdr = {1'b0, r3_pd} + ((ROM_FRAC + FB + 1)'(1) << (FB - 1));
        n4_v   = r3_a - s4_pdr[ROM_FRAC+FB:FB];
    end

    t_curve           r4_curve;
    logic             r4_zero;
    logic             r4_full;
    logic [FB:0]      r4_res;
    logic [2*FB:0]    r4_pc;
    logic [2*FB+1:0]  r4_p1;
    logic [ROM_W-1:0] r4_v;
    logic [3:0]       r4_n;

    // Stage 5: rounding of the products; exponential results are final here.
    logic [FB:0]     n5_t3r;
    logic [FB+1:0]   n5_c1r;
    logic [FB:0]     n5_res;
    logic [2*FB+1:0] s5_rc;
    logic [2*FB+2:0] s5_r1;
    logic [4:0]      s5_sh;
    logic [31:0]     s5_er;

    always_comb begin
        s5_rc  = {1'b0, r4_pc} + ((2 * FB + 2)'(1) << (FB - 1));
        s5_r1  = {1'b0, r4_p1} + ((2 * FB + 3)'(1) << (FB - 1));
        n5_t3r = s5_rc[2*FB:FB];
        n5_c1r = s5_r1[2*FB+1:FB];
        s5_sh  = 5'(r4_n) + EXP_SH0;
        s5_er  = ({1'b0, r4_v} + (32'd1 << (s5_sh - 5'd1))) >> s5_sh;
        case (r4_curve)
            CRV_IN_EXPO:  n5_res = s5_er[FB:0];
            CRV_OUT_EXPO: n5_res = ONE_P - s5_er[FB:0];
            default:      n5_res = r4_res;
        endcase
    end

    t_curve          r5_curve;
    logic            r5_zero;
    logic            r5_full;
    logic [FB:0]     r5_res;
    logic [FB:0]     r5_t3r;
    logic [FB+1:0]   r5_c1r;

    // Stage 6: scaled cube for the back curves.
    logic [2*FB+2:0] n6_p3;

    always_comb begin
        n6_p3 = (2 * FB + 3)'(C3_Q) * (2 * FB + 3)'(r5_t3r);
    end

    t_curve          r6_curve;
    logic            r6_zero;
    logic            r6_full;
    logic [FB:0]     r6_res;
    logic [FB+1:0]   r6_c1r;
    logic [2*FB+2:0] r6_p3;

    // Stage 7: back curve combination, end points, saturation.
    logic signed [OW-1:0]  n7_eased;
    logic [2*FB+3:0]       s7_r3;
    logic signed [FB+3:0]  s7_c3;
    logic signed [FB+3:0]  s7_c1;
    logic signed [FB+3:0]  s7_val;

    always_comb begin
        s7_r3 = {1'b0, r6_p3} + ((2 * FB + 4)'(1) << (FB - 1));
        s7_c3 = signed'((FB + 4)'(s7_r3[2*FB+2:FB]));
        s7_c1 = signed'((FB + 4)'(r6_c1r));
        case (r6_curve)
            CRV_IN_BACK:  s7_val = s7_c3 - s7_c1;
            CRV_OUT_BACK: s7_val = signed'((FB + 4)'(ONE_P)) + s7_c1 - s7_c3;
            default:      s7_val = signed'((FB + 4)'(r6_res));
        endcase
        if (r6_zero) begin
            s7_val = '0;
        end else if (r6_full) begin
            s7_val = signed'((FB + 4)'(ONE_P));
        end
        if (s7_val > SAT_HI) begin
            n7_eased = SAT_HI[OW-1:0];
        end else if (s7_val < SAT_LO) begin
            n7_eased = SAT_LO[OW-1:0];
        end else begin
            n7_eased = s7_val[OW-1:0];
        end
    end

    logic signed [OW-1:0] r7_eased;

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r1_curve <= n1_curve;
            r1_zero  <= n1_zero;
            r1_full  <= n1_full;
            r1_hi    <= n1_hi;
            r1_seg   <= n1_seg;
            r1_x     <= n1_x;
            r1_m     <= n1_m;
            r1_n     <= n1_n;
            r1_idx   <= n1_idx;
            r1_rem   <= n1_rem;
        end
        if (rdy[2]) begin
            r2_curve <= r1_curve;
            r2_zero  <= r1_zero;
            r2_full  <= r1_full;
            r2_hi    <= r1_hi;
            r2_seg   <= r1_seg;
            r2_x     <= r1_x;
            r2_sq    <= n2_sq;
            r2_a     <= n2_a;
            r2_d     <= n2_d;
            r2_n     <= r1_n;
            r2_rem   <= r1_rem;
        end
        if (rdy[3]) begin
            r3_curve <= r2_curve;
            r3_zero  <= r2_zero;
            r3_full  <= r2_full;
            r3_x     <= r2_x;
            r3_t2r   <= n3_t2r;
            r3_res   <= n3_res;
            r3_a     <= r2_a;
            r3_n     <= r2_n;
            r3_pd    <= n3_pd;
        end
        if (rdy[4]) begin
            r4_curve <= r3_curve;
            r4_zero  <= r3_zero;
            r4_full  <= r3_full;
            r4_res   <= r3_res;
            r4_pc    <= n4_pc;
            r4_p1    <= n4_p1;
            r4_v     <= n4_v;
            r4_n     <= r3_n;
        end
        if (rdy[5]) begin
            r5_curve <= r4_curve;
            r5_zero  <= r4_zero;
            r5_full  <= r4_full;
            r5_res   <= n5_res;
            r5_t3r   <= n5_t3r;
            r5_c1r   <= n5_c1r;
        end
        if (rdy[6]) begin
            r6_curve <= r5_curve;
            r6_zero  <= r5_zero;
            r6_full  <= r5_full;
            r6_res   <= r5_res;
            r6_c1r   <= r5_c1r;
            r6_p3    <= n6_p3;
        end
        if (rdy[7]) begin
            r7_eased <= n7_eased;
        end
    end

    assign o_eased = r7_eased;

endmodule

`default_nettype wire

// File: src/ece_chk.sv
// Port-level checker for the easing curve evaluator, with its bind statement.
// Depends only on the ports of easing_curve_eval_core.
`default_nettype none

module ece_chk #(
    parameter int FRAC_BITS = 16
) (
    input wire                         i_clk,
    input wire                         i_rst_n,
    input wire                         i_valid,
    input wire                         o_ready,
    input wire  [3:0]                  i_curve,
    input wire  [FRAC_BITS:0]          i_progress,
    input wire                         o_valid,
    input wire                         i_ready,
    input wire  signed [FRAC_BITS+1:0] o_eased
);

    // The pipeline is empty right after reset.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("o_valid high after reset");

    // A result that is not taken holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_eased))
        else $error("stalled output transaction changed");

    // When the receiver takes results, the whole pipeline advances.
    a_ready_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ready |-> o_ready)
        else $error("input stalled while the output side is ready");

    // Zero progress gives zero at the output when nothing stalls.
    a_zero_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_progress == '0 && i_ready)
        ##1 i_ready ##1 i_ready ##1 i_ready ##1 i_ready ##1 i_ready ##1 i_ready
        |=> o_valid && o_eased == '0)
        else $error("zero progress did not give zero after six cycles");

endmodule

bind easing_curve_eval_core ece_chk #(.FRAC_BITS(FRAC_BITS)) u_ece_chk (.*);

`default_nettype wire
